// ----- rtl/lant_pkg.sv -----
package lant_pkg;

	localparam int CFG_W     = 8;
	localparam int REG_IDX_W = 1;
	localparam int COORD_W   = 7;
	localparam int CMP_W     = 16;

	localparam logic [CFG_W-1:0] GRID_RESET = 8'd128;

	localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

	localparam logic [1:0] HEAD_Y_UP = 2'd0;
	localparam logic [1:0] HEAD_X_UP = 2'd1;
	localparam logic [1:0] HEAD_Y_DN = 2'd2;
	localparam logic [1:0] HEAD_X_DN = 2'd3;

	typedef enum logic [1:0] {
		KIND_STEP    = 2'd0,
		KIND_READ    = 2'd1,
		KIND_RESTART = 2'd2,
		KIND_NOP     = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_RD,
		S_DONE
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic [COORD_W-1:0] read_x;
		logic [COORD_W-1:0] read_y;
	} cmd_t;

	typedef struct packed {
		logic [COORD_W-1:0] ant_col;
		logic [COORD_W-1:0] ant_row;
		logic [1:0]         heading;
		logic               cell_value;
	} rsp_t;

endpackage

// ----- rtl/lant_chan_if.sv -----
interface lant_chan_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// ----- rtl/lant_ram.sv -----
module lant_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/lant_rem.sv -----
// Restoring remainder, one dividend bit per cycle. VW must be >= DW.
module lant_rem #(
	parameter int DW = 7,
	parameter int VW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] rem
);

	localparam int CNTW = $clog2(DW + 1);

	logic            busy_q;
	logic [CNTW-1:0] cnt_q;
	logic [VW-1:0]   rem_q;
	logic [DW-1:0]   dvd_q;
	logic [VW:0]     trial;
	logic [VW:0]     diff;
	logic [VW-1:0]   rem_nx;

	always_comb begin
		trial  = {rem_q, dvd_q[DW-1]};
		diff   = trial - {1'b0, divisor};
		rem_nx = (trial >= {1'b0, divisor}) ? diff[VW-1:0] : trial[VW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= dvd_q << 1;
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q[DW-1:0];

endmodule

// ----- rtl/langton_ant_step.sv -----
// Step and in-window read: accept + grid row read, then flip/write-back and result register;
// S_RD waits while the result register is full, and commands are taken only in S_IDLE.
// A step after the window shrank below the ant first wraps its position in the remainder
// units. Restart: a row-by-row clearing pass over the grid memory, then the result.
// Reset: ant at the centre heading x-up, then a clearing pass over the grid memory
// (one row per cycle) during which no command is taken; config writes still land.
module langton_ant_step import lant_pkg::*; #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	lant_chan_if.sink            cmd,
	lant_chan_if.source          rsp
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int CH = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RST_W = (MAX_WIDTH < int'(GRID_RESET)) ? MAX_WIDTH : int'(GRID_RESET);
	localparam int RST_H = (MAX_HEIGHT < int'(GRID_RESET)) ? MAX_HEIGHT : int'(GRID_RESET);
	localparam logic [CW-1:0] RST_COL  = CW'(RST_W / 2);
	localparam logic [CH-1:0] RST_ROW  = CH'(RST_H / 2);
	localparam logic [CH-1:0] CLR_LAST = CH'(MAX_HEIGHT - 1);

	state_t state_q, state_d;

	logic [CFG_W-1:0] gw_q, gh_q;
	logic [CMP_W-1:0] w16, h16;
	logic [WW-1:0]    act_w, half_w, col_inc, w_m1;
	logic [HW-1:0]    act_h, half_h, row_inc, h_m1;

	logic [CW-1:0] col_q, col_nxt, rcol_q, rcol_idx, rem_col;
	logic [CH-1:0] row_q, row_nxt, rrow_idx, rem_row, clr_cnt_q;
	logic [1:0]    head_q, head_new;
	logic          restart_q;
	kind_t         kind_q;

	logic [CW+6:0] rx_wide, col_wide, coln_wide;
	logic [CH+6:0] ry_wide, row_wide, rown_wide;

	logic                 ram_we, ram_re;
	logic [CH-1:0]        ram_waddr, ram_raddr;
	logic [MAX_WIDTH-1:0] ram_wdata, ram_rdata, flip_row;

	logic rem_start, rem_col_busy, rem_row_busy;
	logic cmd_ready, accept, in_range, need_mod, cell_bit, out_free, out_load, step_upd;
	logic out_valid_q;
	rsp_t rsp_q, out_data;

	// clamp sizes: zero acts as one, above the array bound acts as the bound
	always_comb begin
		w16 = (gw_q == '0) ? CMP_W'(1) :
		      (CMP_W'(gw_q) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : CMP_W'(gw_q);
		h16 = (gh_q == '0) ? CMP_W'(1) :
		      (CMP_W'(gh_q) > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT) : CMP_W'(gh_q);
		act_w  = w16[WW-1:0];
		act_h  = h16[HW-1:0];
		half_w = act_w >> 1;
		half_h = act_h >> 1;
		w_m1   = act_w - WW'(1);
		h_m1   = act_h - HW'(1);
	end

	always_comb begin
		rx_wide  = {{CW{1'b0}}, cmd.data.read_x};
		ry_wide  = {{CH{1'b0}}, cmd.data.read_y};
		rcol_idx = rx_wide[CW-1:0];
		rrow_idx = ry_wide[CH-1:0];
		in_range = (CMP_W'(cmd.data.read_x) < CMP_W'(act_w)) &&
		           (CMP_W'(cmd.data.read_y) < CMP_W'(act_h));
		need_mod = (WW'(col_q) >= act_w) || (HW'(row_q) >= act_h);
	end

	// step datapath on the row just read
	always_comb begin
		cell_bit = ram_rdata[col_q];
		head_new = cell_bit ? (head_q - 2'd1) : (head_q + 2'd1);
		flip_row = ram_rdata ^ (MAX_WIDTH'(1) << col_q);
		col_inc  = WW'(col_q) + WW'(1);
		row_inc  = HW'(row_q) + HW'(1);
		col_nxt  = col_q;
		row_nxt  = row_q;
		unique case (head_new)
			HEAD_Y_UP: row_nxt = (row_inc >= act_h) ? '0 : row_inc[CH-1:0];
			HEAD_X_UP: col_nxt = (col_inc >= act_w) ? '0 : col_inc[CW-1:0];
			HEAD_Y_DN: row_nxt = (row_q == '0) ? h_m1[CH-1:0] : row_q - CH'(1);
			HEAD_X_DN: col_nxt = (col_q == '0) ? w_m1[CW-1:0] : col_q - CW'(1);
			default: ;
		endcase
		col_wide  = {7'b0, col_q};
		row_wide  = {7'b0, row_q};
		coln_wide = {7'b0, col_nxt};
		rown_wide = {7'b0, row_nxt};
	end

	assign out_free = !out_valid_q || rsp.ready;
	assign accept   = cmd.valid && cmd_ready;

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = row_q;
		ram_wdata = flip_row;
		ram_re    = 1'b0;
		ram_raddr = row_q;
		rem_start = 1'b0;
		out_load  = 1'b0;
		step_upd  = 1'b0;
		out_data  = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '0;
				if (clr_cnt_q == CLR_LAST) begin
					state_d = restart_q ? S_DONE : S_IDLE;
				end
			end
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd.valid) begin
					unique case (cmd.data.kind)
						KIND_STEP: begin
							if (need_mod) begin
								rem_start = 1'b1;
								state_d   = S_MOD;
							end else begin
								ram_re  = 1'b1;
								state_d = S_RD;
							end
						end
						KIND_READ: begin
							if (in_range) begin
								ram_re    = 1'b1;
								ram_raddr = rrow_idx;
								state_d   = S_RD;
							end else begin
								state_d = S_DONE;
							end
						end
						KIND_RESTART: state_d = S_CLEAR;
						default:      state_d = S_DONE;
					endcase
				end
			end
			S_MOD: begin
				if (!rem_col_busy && !rem_row_busy) begin
					ram_re    = 1'b1;
					ram_raddr = rem_row;
					state_d   = S_RD;
				end
			end
			S_RD: begin
				// read data holds until the output register frees up
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
					if (kind_q == KIND_STEP) begin
						ram_we              = 1'b1;
						step_upd            = 1'b1;
						out_data.ant_col    = coln_wide[COORD_W-1:0];
						out_data.ant_row    = rown_wide[COORD_W-1:0];
						out_data.heading    = head_new;
						out_data.cell_value = ~cell_bit;
					end else begin
						out_data.ant_col    = col_wide[COORD_W-1:0];
						out_data.ant_row    = row_wide[COORD_W-1:0];
						out_data.heading    = head_q;
						out_data.cell_value = ram_rdata[rcol_q];
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_load            = 1'b1;
					state_d             = S_IDLE;
					out_data.ant_col    = col_wide[COORD_W-1:0];
					out_data.ant_row    = row_wide[COORD_W-1:0];
					out_data.heading    = head_q;
					out_data.cell_value = 1'b0;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			restart_q   <= 1'b0;
			gw_q        <= GRID_RESET;
			gh_q        <= GRID_RESET;
			col_q       <= RST_COL;
			row_q       <= RST_ROW;
			head_q      <= HEAD_X_UP;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_WIDTH:  gw_q <= cfg_wdata;
					REG_GRID_HEIGHT: gh_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == S_CLEAR) begin
				if (clr_cnt_q == CLR_LAST) begin
					clr_cnt_q <= '0;
					restart_q <= 1'b0;
					if (restart_q) begin
						col_q  <= half_w[CW-1:0];
						row_q  <= half_h[CH-1:0];
						head_q <= HEAD_X_UP;
					end
				end else begin
					clr_cnt_q <= clr_cnt_q + CH'(1);
				end
			end
			if (accept && cmd.data.kind == KIND_RESTART) begin
				restart_q <= 1'b1;
				clr_cnt_q <= '0;
			end
			if (state_q == S_MOD && state_d == S_RD) begin
				col_q <= rem_col;
				row_q <= rem_row;
			end
			if (step_upd) begin
				col_q  <= col_nxt;
				row_q  <= row_nxt;
				head_q <= head_new;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= cmd.data.kind;
			rcol_q <= rcol_idx;
		end
		if (out_load) begin
			rsp_q <= out_data;
		end
	end

	assign cmd.ready = cmd_ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = rsp_q;

	lant_ram #(
		.WIDTH (MAX_WIDTH),
		.DEPTH (MAX_HEIGHT)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lant_rem #(
		.DW (CW),
		.VW (WW)
	) u_rem_col (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (col_q),
		.divisor  (act_w),
		.busy     (rem_col_busy),
		.rem      (rem_col)
	);

	lant_rem #(
		.DW (CH),
		.VW (HW)
	) u_rem_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (row_q),
		.divisor  (act_h),
		.busy     (rem_row_busy),
		.rem      (rem_row)
	);

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_we)
		else $error("grid write while idle");

	a_rd_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD && $past(state_q) != S_RD) |-> $past(ram_re))
		else $error("row data used without a read");

	a_rem_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_col_busy || rem_row_busy) |-> (state_q == S_MOD))
		else $error("remainder unit busy outside wrap state");

	a_head_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == S_RD || state_q == S_CLEAR) |=> $stable(head_q))
		else $error("heading changed outside step or restart");

	a_restart_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.data.kind == KIND_RESTART) |=> (state_q == S_CLEAR && clr_cnt_q == '0))
		else $error("restart did not start a clear sweep");

endmodule
